@@ rtl/lpht_pkg.sv @@
package lpht_pkg;

  localparam int KEY_W  = 256;
  localparam int PAY_W  = 64;
  localparam int FLAG_W = 2;
  localparam int HASH_W = 64;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2,
    ST_RSVD   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_FREE_CHK,
    S_WRITE,
    S_ER_RD,
    S_ER_CHK,
    S_ER_FREE,
    S_ER_MOVE,
    S_RESULT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_used;     // write zero to used store at cursor
    logic load_req;     // capture the request word
    logic cur_inc;      // cursor <- cursor + 1 (wrap)
    logic cur_zero;     // cursor <- 0
    logic rd;           // issue read at cursor
    logic set_found;    // latch found slot and entry contents
    logic upd_flags;    // OR flags into found slot
    logic ins_new;      // write new entry at cursor
    logic er_free;      // clear used bit at found slot, decrement count
    logic nx_start;     // erase scan pointer <- found + 1
    logic nx_inc;       // erase scan pointer advance
    logic dst_home;     // dst <- home of scanned entry
    logic dst_inc;      // dst advance
    logic mv_write;     // copy scanned entry to dst, clear nx
    logic res_absent;   // result: key absent
    logic res_full;     // result: refused
    logic res_valid;    // present result to output
  } lpht_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rd_used;      // used bit of last read slot
    logic key_match;    // key of last read matches request
    logic dst_used;     // used bit at dst
    logic dst_is_nx;    // dst equals scanned slot
    logic wrap_last;    // cursor at last slot
    logic probe_end;    // probe visited every slot
    logic load_full;    // count at or above 3/4 load
    logic out_busy;     // output register still holds a word
    op_t  op;
  } lpht_sts_t;

endpackage

@@ rtl/lpht_ram.sv @@
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lpht_ctrl.sv @@
module lpht_ctrl import lpht_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lpht_sts_t sts,
  output lpht_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_used = 1'b1;
        cmd.cur_inc  = 1'b1;
        if (sts.wrap_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = !sts.out_busy;
        if (in_valid && !sts.out_busy) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_FIND_RD;
        end
      end
      S_FIND_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_FIND_CHK;
      end
      S_FIND_CHK: begin
        if (!sts.rd_used || sts.probe_end) begin
          // key absent
          if (sts.op == OP_INSERT) begin
            if (sts.load_full || sts.probe_end) begin
              cmd.res_full = 1'b1;
              state_nxt    = S_RESULT;
            end else if (!sts.rd_used) begin
              state_nxt = S_WRITE;
            end else begin
              cmd.res_full = 1'b1;
              state_nxt    = S_RESULT;
            end
          end else begin
            cmd.res_absent = 1'b1;
            state_nxt      = S_RESULT;
          end
        end else if (sts.key_match) begin
          cmd.set_found = 1'b1;
          case (sts.op)
            OP_INSERT: begin
              cmd.upd_flags = 1'b1;
              state_nxt     = S_RESULT;
            end
            OP_ERASE: begin
              cmd.er_free  = 1'b1;
              cmd.nx_start = 1'b1;
              state_nxt    = S_ER_RD;
            end
            default: state_nxt = S_RESULT;
          endcase
        end else begin
          cmd.cur_inc = 1'b1;
          state_nxt   = S_FIND_RD;
        end
      end
      S_WRITE: begin
        cmd.ins_new  = 1'b1;
        state_nxt    = S_RESULT;
      end
      S_ER_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_ER_CHK;
      end
      S_ER_CHK: begin
        if (!sts.rd_used || sts.probe_end) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.dst_home = 1'b1;
          state_nxt    = S_ER_FREE;
        end
      end
      S_ER_FREE: begin
        // first free slot from home, treating the scanned slot as free
        if (sts.dst_is_nx) begin
          cmd.nx_inc = 1'b1;
          state_nxt  = S_ER_RD;
        end else if (!sts.dst_used) begin
          state_nxt = S_ER_MOVE;
        end else begin
          cmd.dst_inc = 1'b1;
        end
      end
      S_ER_MOVE: begin
        cmd.mv_write = 1'b1;
        cmd.nx_inc   = 1'b1;
        state_nxt    = S_ER_RD;
      end
      S_RESULT: begin
        cmd.res_valid = 1'b1;
        cmd.cur_zero  = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ rtl/lpht_dp.sv @@
module lpht_dp import lpht_pkg::*; #(
  parameter int NUM_SLOTS = 4096,
  parameter int IDX_W     = 12,
  parameter int CNT_W     = 13
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lpht_cmd_t         cmd,
  output lpht_sts_t         sts,
  input  logic [1:0]        in_op,
  input  logic [63:0]       in_key_word0,
  input  logic [63:0]       in_key_word1,
  input  logic [63:0]       in_key_word2,
  input  logic [63:0]       in_key_word3,
  input  logic [HASH_W-1:0] in_key_hash,
  input  logic [FLAG_W-1:0] in_flag_bits,
  input  logic [PAY_W-1:0]  in_payload_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic              out_was_present,
  output logic [11:0]       out_slot_index,
  output logic [FLAG_W-1:0] out_flags_out,
  output logic [PAY_W-1:0]  out_payload_out,
  output logic [12:0]       out_entry_count
);

  localparam int ENT_W = KEY_W + IDX_W + FLAG_W + PAY_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_SLOTS - 1);

  // request word
  op_t               op_r;
  logic [KEY_W-1:0]  key_r;
  logic [IDX_W-1:0]  home_r;
  logic [FLAG_W-1:0] fl_r;
  logic [PAY_W-1:0]  pay_r;

  logic [IDX_W-1:0]  cur_r, nx_r, dst_r;
  logic [IDX_W:0]    steps_r;
  logic [CNT_W-1:0]  count_r;

  logic [1:0]        status_r;
  logic              present_r, ovalid_r;
  logic [11:0]       sidx_r;
  logic [FLAG_W-1:0] oflags_r;
  logic [PAY_W-1:0]  opay_r;

  function automatic logic [IDX_W-1:0] inc(input logic [IDX_W-1:0] s);
    return (s == LAST) ? '0 : s + 1'b1;
  endfunction

  // entry store: key, home, flags, payload in one word
  logic             ent_we;
  logic [IDX_W-1:0] ent_wa, ent_ra;
  logic [ENT_W-1:0] ent_wd, ent_rd;
  logic             used_we, used_wd, used_rd;
  logic [IDX_W-1:0] used_wa, used_ra;

  logic [KEY_W-1:0]  rd_key;
  logic [IDX_W-1:0]  rd_home;
  logic [FLAG_W-1:0] rd_flags;
  logic [PAY_W-1:0]  rd_pay;
  assign {rd_key, rd_home, rd_flags, rd_pay} = ent_rd;

  // one used-bit read per cycle: scan pointer in erase scan, dst in free search
  logic erase_phase_r;

  always_comb begin
    ent_we  = 1'b0;
    ent_wa  = cur_r;
    ent_wd  = {key_r, home_r, fl_r, pay_r};
    used_we = 1'b0;
    used_wa = cur_r;
    used_wd = 1'b0;
    if (cmd.clr_used) begin
      used_we = 1'b1;
    end else if (cmd.ins_new) begin
      ent_we  = 1'b1;
      used_we = 1'b1;
      used_wd = 1'b1;
    end else if (cmd.upd_flags) begin
      ent_we = 1'b1;
      ent_wa = cur_r;
      ent_wd = {rd_key, rd_home, rd_flags | fl_r, rd_pay};
    end else if (cmd.er_free) begin
      used_we = 1'b1;
      used_wa = cur_r;
    end else if (cmd.mv_write) begin
      ent_we  = 1'b1;
      ent_wa  = dst_r;
      ent_wd  = ent_rd;
      used_we = 1'b1;
      used_wa = dst_r;
      used_wd = 1'b1;
    end
  end

  // entry read held at scan pointer during erase, cursor during probe
  assign ent_ra  = erase_phase_r ? nx_r : cur_r;
  // free search reads ahead at the slot dst moves to, so used_rd tracks dst_r
  assign used_ra = cmd.rd       ? ent_ra :
                   cmd.dst_home ? rd_home :
                   cmd.dst_inc  ? inc(dst_r) : dst_r;

  lpht_ram #(.WIDTH(ENT_W), .DEPTH(NUM_SLOTS)) u_ent (
    .clk(clk), .we(ent_we), .waddr(ent_wa), .wdata(ent_wd),
    .raddr(ent_ra), .rdata(ent_rd)
  );

  // used bit store: mv clears the source through a second write cycle
  logic mv_clr_r;
  logic [IDX_W-1:0] mv_src_r;
  logic             uwe;
  logic [IDX_W-1:0] uwa;
  logic             uwd;
  always_comb begin
    uwe = used_we;
    uwa = used_wa;
    uwd = used_wd;
    if (mv_clr_r) begin
      uwe = 1'b1;
      uwa = mv_src_r;
      uwd = 1'b0;
    end
  end

  lpht_ram #(.WIDTH(1), .DEPTH(NUM_SLOTS)) u_used (
    .clk(clk), .we(uwe), .waddr(uwa), .wdata(uwd),
    .raddr(used_ra), .rdata(used_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_clr_r <= 1'b0;
    end else begin
      mv_clr_r <= cmd.mv_write;
    end
  end
  always_ff @(posedge clk) begin
    mv_src_r <= nx_r;
  end

  assign sts.rd_used   = used_rd;
  assign sts.key_match = (rd_key == key_r);
  assign sts.dst_used  = used_rd;
  assign sts.dst_is_nx = (dst_r == nx_r);
  assign sts.wrap_last = (cur_r == LAST);
  assign sts.probe_end = (steps_r == (IDX_W + 1)'(NUM_SLOTS));
  assign sts.load_full = ({2'b00, count_r} << 2) >= (CNT_W + 2)'(NUM_SLOTS * 3);
  assign sts.out_busy  = ovalid_r;
  assign sts.op        = op_r;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r   <= op_t'(in_op);
      key_r  <= {in_key_word3, in_key_word2, in_key_word1, in_key_word0};
      home_r <= in_key_hash[IDX_W-1:0];
      fl_r   <= in_flag_bits;
      pay_r  <= in_payload_in;
    end
    if (cmd.nx_start) begin
      nx_r <= inc(cur_r);
    end else if (cmd.nx_inc) begin
      nx_r <= inc(nx_r);
    end
    if (cmd.dst_home) begin
      dst_r <= rd_home;
    end else if (cmd.dst_inc) begin
      dst_r <= inc(dst_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r         <= '0;
      steps_r       <= '0;
      count_r       <= '0;
      erase_phase_r <= 1'b0;
    end else begin
      if (cmd.load_req) begin
        cur_r         <= in_key_hash[IDX_W-1:0];
        steps_r       <= '0;
        erase_phase_r <= 1'b0;
      end else if (cmd.cur_zero) begin
        cur_r         <= '0;
        erase_phase_r <= 1'b0;
      end else if (cmd.cur_inc) begin
        cur_r <= inc(cur_r);
      end
      if (cmd.rd) begin
        steps_r <= steps_r + 1'b1;
      end
      if (cmd.nx_start) begin
        erase_phase_r <= 1'b1;
        steps_r       <= '0;
      end
      if (cmd.ins_new) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.er_free && count_r != '0) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.res_valid) begin
      ovalid_r <= 1'b1;
    end else if (out_ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_absent || cmd.res_full) begin
      status_r  <= cmd.res_full ? ST_FULL : ST_ABSENT;
      present_r <= 1'b0;
      sidx_r    <= '0;
      oflags_r  <= '0;
      opay_r    <= '0;
    end else if (cmd.ins_new) begin
      status_r  <= ST_DONE;
      present_r <= 1'b0;
      sidx_r    <= 12'(cur_r);
      oflags_r  <= fl_r;
      opay_r    <= pay_r;
    end else if (cmd.set_found) begin
      status_r  <= ST_DONE;
      present_r <= 1'b1;
      sidx_r    <= 12'(cur_r);
      oflags_r  <= cmd.upd_flags ? (rd_flags | fl_r) : rd_flags;
      opay_r    <= rd_pay;
    end
  end

  assign out_valid       = ovalid_r;
  assign out_status      = status_r;
  assign out_was_present = present_r;
  assign out_slot_index  = sidx_r;
  assign out_flags_out   = oflags_r;
  assign out_payload_out = opay_r;
  assign out_entry_count = 13'(count_r);

endmodule

@@ rtl/linear_probe_hash_table.sv @@
// Channel   Ports                                Direction  Handshake
// request   in_op .. in_payload_in               in         in_valid / in_ready
// result    out_status .. out_entry_count        out        out_valid / out_ready
//
// Lookup, flag update and refused insert probe slot by slot from the home slot
// until a match, an empty slot or a full lap; a new insert adds one write.
// Erase then scans the cluster after the erased slot (the empty slot that ends
// it included), searches from each scanned entry's home for a free slot and
// moves the entry there unless that slot is its own.
// Speed is set by the single read port of the entry RAM.
// Reset: a clearing pass over all NUM_SLOTS slots zeroes the used store; no word
// is accepted until it ends.
// Stalls: the result sits in an output register; a new word is taken once it
// has been consumed.
module linear_probe_hash_table import lpht_pkg::*; #(
  parameter int NUM_SLOTS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_key_word0,
  input  logic [63:0] in_key_word1,
  input  logic [63:0] in_key_word2,
  input  logic [63:0] in_key_word3,
  input  logic [63:0] in_key_hash,
  input  logic [1:0]  in_flag_bits,
  input  logic [63:0] in_payload_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_was_present,
  output logic [11:0] out_slot_index,
  output logic [1:0]  out_flags_out,
  output logic [63:0] out_payload_out,
  output logic [12:0] out_entry_count
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  lpht_cmd_t cmd;
  lpht_sts_t sts;

  // sequencer: probe, insert, erase with re-placement
  lpht_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  // stores, pointers, count and output register
  lpht_dp #(.NUM_SLOTS(NUM_SLOTS), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_op(in_op), .in_key_word0(in_key_word0), .in_key_word1(in_key_word1),
    .in_key_word2(in_key_word2), .in_key_word3(in_key_word3),
    .in_key_hash(in_key_hash), .in_flag_bits(in_flag_bits),
    .in_payload_in(in_payload_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_was_present(out_was_present), .out_slot_index(out_slot_index),
    .out_flags_out(out_flags_out), .out_payload_out(out_payload_out),
    .out_entry_count(out_entry_count)
  );

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  import lpht_pkg::*;

  localparam int SLOTS = 4096;
  localparam int MAX_CYCLES = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [63:0] in_key_word0, in_key_word1, in_key_word2, in_key_word3;
  logic [63:0] in_key_hash;
  logic [1:0]  in_flag_bits;
  logic [63:0] in_payload_in;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic        out_was_present;
  logic [11:0] out_slot_index;
  logic [1:0]  out_flags_out;
  logic [63:0] out_payload_out;
  logic [12:0] out_entry_count;

  linear_probe_hash_table #(.NUM_SLOTS(SLOTS)) dut (.*);

  typedef struct packed {
    logic [1:0]   op;
    logic [255:0] key;
    logic [63:0]  hash;
    logic [1:0]   flags;
    logic [63:0]  payload;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        present;
    logic [11:0] slot;
    logic [1:0]  flags;
    logic [63:0] payload;
    logic [12:0] count;
  } answer_t;

  // Shadow copy of the table
  bit           tbl_used [SLOTS];
  logic [255:0] tbl_key  [SLOTS];
  logic [11:0]  tbl_home [SLOTS];
  logic [1:0]   tbl_flags[SLOTS];
  logic [63:0]  tbl_pay  [SLOTS];
  int           tbl_count;

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  logic [255:0] key_pool[$];

  int  mismatches;
  bit  stim_done;
  int  cycle_cnt;
  bit  hold_off;      // long receiver stall window
  int  run_cycles;    // cycles since reset, for the hold-off window

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int wrap_next(int s);
    return (s + 1 >= SLOTS) ? 0 : s + 1;
  endfunction

  function automatic int find_free(int home);
    int s;
    s = home;
    for (int i = 0; i < SLOTS; i++) begin
      if (!tbl_used[s]) return s;
      s = wrap_next(s);
    end
    return -1;
  endfunction

  // Predict one answer and update the shadow table
  function automatic answer_t apply_request(request_t r);
    answer_t a;
    int home, s, nx, dst;
    bit found;
    a = '0;
    a.status = ST_ABSENT;
    home = int'(r.hash[11:0]);
    found = 0;
    s = home;
    for (int i = 0; i < SLOTS; i++) begin
      if (!tbl_used[s]) break;
      if (tbl_key[s] == r.key) begin
        found = 1;
        break;
      end
      s = wrap_next(s);
    end
    if (r.op == OP_INSERT) begin
      if (found) begin
        tbl_flags[s] = tbl_flags[s] | r.flags;
        a.status = ST_DONE; a.present = 1; a.slot = 12'(s);
        a.flags = tbl_flags[s]; a.payload = tbl_pay[s];
      end else begin
        dst = (tbl_count * 4 >= SLOTS * 3) ? -1 : find_free(home);
        if (dst < 0) a.status = ST_FULL;
        else begin
          tbl_used[dst] = 1; tbl_key[dst] = r.key; tbl_home[dst] = 12'(home);
          tbl_flags[dst] = r.flags; tbl_pay[dst] = r.payload;
          tbl_count++;
          a.status = ST_DONE; a.slot = 12'(dst);
          a.flags = r.flags; a.payload = r.payload;
        end
      end
    end else if (r.op == OP_ERASE) begin
      if (found) begin
        a.status = ST_DONE; a.present = 1; a.slot = 12'(s);
        a.flags = tbl_flags[s]; a.payload = tbl_pay[s];
        tbl_used[s] = 0;
        if (tbl_count > 0) tbl_count--;
        // re-place the rest of the cluster
        nx = wrap_next(s);
        for (int i = 0; i < SLOTS && tbl_used[nx]; i++) begin
          tbl_used[nx] = 0;
          dst = find_free(int'(tbl_home[nx]));
          if (dst >= 0 && dst != nx) begin
            tbl_key[dst] = tbl_key[nx]; tbl_home[dst] = tbl_home[nx];
            tbl_flags[dst] = tbl_flags[nx]; tbl_pay[dst] = tbl_pay[nx];
            tbl_used[dst] = 1;
          end else begin
            tbl_used[nx] = 1;
          end
          nx = wrap_next(nx);
        end
      end
    end else if (found) begin
      a.status = ST_DONE; a.present = 1; a.slot = 12'(s);
      a.flags = tbl_flags[s]; a.payload = tbl_pay[s];
    end
    a.count = tbl_count[12:0];
    return a;
  endfunction

  function automatic logic [255:0] rand_key();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom};
  endfunction

  // Keys hash into a narrow window so clusters form and collide
  function automatic logic [63:0] key_hash_of(logic [255:0] k, int spread);
    logic [63:0] h;
    h = k[63:0] ^ k[127:64] ^ k[191:128] ^ k[255:192];
    h[11:0] = 12'((h[11:0] % spread) + 4000);
    return h;
  endfunction

  task automatic push_req(logic [1:0] op, logic [255:0] k, logic [63:0] h,
                          logic [1:0] f, logic [63:0] p);
    request_t r;
    r.op = op; r.key = k; r.hash = h; r.flags = f; r.payload = p;
    pending_reqs.push_back(r);
  endtask

  // Stimulus: directed part then random mix
  initial begin : stimulus
    logic [255:0] k;
    int pick;
    logic [1:0] op;
    stim_done = 0;
    // empty table, absent key, odd op
    push_req(OP_LOOKUP, '0, '0, 2'd0, '0);
    push_req(OP_ERASE, '1, '1, 2'd3, '1);
    push_req(OP_NONE, '1, 64'hFFF, 2'd3, '1);
    // insert with extreme fields, update flags, re-read
    push_req(OP_INSERT, '1, '1, 2'd1, '1);
    push_req(OP_INSERT, '1, '1, 2'd2, '0);
    push_req(OP_LOOKUP, '1, '1, 2'd0, '0);
    push_req(OP_INSERT, '0, '0, 2'd0, '0);
    // a cluster that wraps past the last slot
    for (int i = 0; i < 5; i++)
      push_req(OP_INSERT, {252'h0, 4'(i + 1)}, 64'hFFE, 2'(i), 64'(i));
    push_req(OP_ERASE, {252'h0, 4'd1}, 64'hFFE, 2'd0, '0);
    push_req(OP_LOOKUP, {252'h0, 4'd5}, 64'hFFE, 2'd0, '0);
    push_req(OP_NONE, {252'h0, 4'd3}, 64'hFFE, 2'd0, '0);
    push_req(OP_ERASE, '1, '1, 2'd0, '0);
    push_req(OP_LOOKUP, '1, '1, 2'd0, '0);
    push_req(OP_ERASE, {252'h0, 4'd3}, 64'hFFE, 2'd0, '0);
    // random: mostly keys from a pool so hits happen
    for (int n = 0; n < 1400; n++) begin
      pick = $urandom_range(0, 99);
      if (key_pool.size() == 0 || pick < 35) begin
        k = rand_key();
        key_pool.push_back(k);
        if (key_pool.size() > 200) key_pool.delete(0);
      end else begin
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end
      pick = $urandom_range(0, 99);
      op = pick < 45 ? OP_INSERT : pick < 70 ? OP_LOOKUP : pick < 97 ? OP_ERASE : OP_NONE;
      push_req(op, k, key_hash_of(k, 150), 2'($urandom), {$urandom, $urandom});
    end
    stim_done = 1;
  end

  // Driver
  int       gap;
  request_t cur_req;
  initial begin
    rst_n = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      gap = 0;
      in_valid      <= 0;
      in_op         <= '0;
      in_key_word0  <= '0;
      in_key_word1  <= '0;
      in_key_word2  <= '0;
      in_key_word3  <= '0;
      in_key_hash   <= '0;
      in_flag_bits  <= '0;
      in_payload_in <= '0;
    end else begin
      if (in_valid && in_ready) begin
        expected_answers.push_back(apply_request(cur_req));
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      end
      if (!in_valid || in_ready) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          in_valid      <= 1;
          in_op         <= cur_req.op;
          in_key_word0  <= cur_req.key[63:0];
          in_key_word1  <= cur_req.key[127:64];
          in_key_word2  <= cur_req.key[191:128];
          in_key_word3  <= cur_req.key[255:192];
          in_key_hash   <= cur_req.hash;
          in_flag_bits  <= cur_req.flags;
          in_payload_in <= cur_req.payload;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // Long receiver hold-off, timed by its own cycle count after reset
  always @(posedge clk) begin
    if (!rst_n) begin
      run_cycles <= 0;
      hold_off   <= 0;
    end else begin
      run_cycles <= run_cycles + 1;
      hold_off   <= (run_cycles >= 10000 && run_cycles < 10400);
    end
  end

  // Monitor: compare each result word with the oldest expectation
  int      stall;
  int      words_seen;
  answer_t got, want;

  always @(posedge clk) begin
    if (!rst_n) begin
      stall = 0;
      words_seen = 0;
      mismatches = 0;
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_status, out_was_present, out_slot_index, out_flags_out,
                out_payload_out, out_entry_count};
        words_seen++;
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %p", got);
        end else begin
          want = expected_answers.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch word %0d: expected %p actual %p",
                       words_seen, want, got);
          end
        end
        stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      end
      if (hold_off) begin
        out_ready <= 0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // End of run and watchdog
  initial begin
    cycle_cnt = 0;
    wait (stim_done);
    while (!(pending_reqs.size() == 0 && !in_valid && expected_answers.size() == 0)
           && cycle_cnt < MAX_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    if (cycle_cnt >= MAX_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      repeat (200) @(posedge clk);
      if (mismatches == 0 && expected_answers.size() == 0)
        $display("Test completed successfully");
      else
        $display("Test completed with failures");
      $finish;
    end
  end

endmodule
